[src/rctc_pkg.sv]
package rctc_pkg;

  localparam int unsigned POSITIONS = 4096;
  localparam int unsigned ADDR_W    = $clog2(POSITIONS);
  localparam int unsigned IN_W      = 12;
  localparam int unsigned COVER_W   = 16;
  localparam int unsigned COUNT_W   = 13;

  localparam logic [COVER_W-1:0] COVER_MAX = {COVER_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [ADDR_W-1:0]  LAST_POS  = ADDR_W'(POSITIONS - 1);
  localparam logic [COVER_W-1:0] THRESHOLD_RST = COVER_W'(1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

endpackage

[src/range_cover_threshold_count.sv]
// Keeps a 16-bit saturating coverage count for each of 4096 positions in one
// single-port-read, single-port-write RAM. An add raises the coverage of every
// position in lower..upper; a query returns, one cycle strobed on out_valid, how
// many positions in lower..upper have coverage of at least the threshold. Each
// item walks its range one RAM entry per cycle, with the read data registered in
// the RAM: busy stays high while the range is walked and then through the drain
// state, so a new item can only start once the last one is through. A query's
// result appears in the cycle in which busy falls. An empty range (lower above
// upper) does not raise busy, and an empty query strobes 0 on the next cycle.
// After reset the block clears the RAM, one entry a cycle, with busy high. The
// result has no back-pressure: it must be taken in the cycle that out_valid is
// high. The threshold write channel is always ready, but should only be written
// while the block is idle.
module range_cover_threshold_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [rctc_pkg::IN_W-1:0]     in_lower,
  input  logic [rctc_pkg::IN_W-1:0]     in_upper,
  output logic                          out_valid,
  output logic [rctc_pkg::COUNT_W-1:0]  out_qualified_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rctc_pkg::COVER_W-1:0]  cfg_data
);

  import rctc_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   last_r;
  logic [ADDR_W-1:0]   rd_addr_q_r;
  logic                rd_vld_r;
  op_t                 op_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COVER_W-1:0]  threshold_r;
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                accept;
  logic                range_empty;
  logic [31:0]         lo_ext, hi_ext, hi_clip;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [COVER_W-1:0]  rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COVER_W-1:0]  wr_data;
  logic                hit;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Positions beyond the store do not exist, so the range is clipped to it.
  assign lo_ext      = 32'(in_lower);
  assign hi_ext      = 32'(in_upper);
  assign hi_clip     = (hi_ext >= 32'(POSITIONS)) ? 32'(POSITIONS - 1) : hi_ext;
  assign range_empty = (lo_ext > hi_ext) || (lo_ext >= 32'(POSITIONS));

  rctc_ram #(
    .WIDTH(COVER_W),
    .DEPTH(POSITIONS)
  ) u_cover_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_en   = (state_r == ST_RUN);
  assign rd_addr = addr_r;
  assign hit     = (rd_data >= threshold_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q_r;
    wr_data = (rd_data == COVER_MAX) ? rd_data : rd_data + COVER_W'(1);
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = addr_r;
      wr_data = '0;
    end else if (rd_vld_r && op_r == OP_ADD) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (rd_vld_r && op_r == OP_QUERY && hit && count_r != COUNT_MAX) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_r + ADDR_W'(1);
        if (addr_r == LAST_POS) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !range_empty) begin
          state_nxt = ST_RUN;
          addr_nxt  = ADDR_W'(lo_ext);
        end
      end
      ST_RUN: begin
        addr_nxt = addr_r + ADDR_W'(1);
        if (addr_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RST;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_en;
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end
      out_valid_r <= (accept && range_empty && in_op == OP_QUERY) ||
                     (state_r == ST_DRAIN && op_r == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q_r <= addr_r;
    if (accept) begin
      op_r    <= op_t'(in_op);
      last_r  <= ADDR_W'(hi_clip);
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    if (accept && range_empty) begin
      out_count_r <= '0;
    end else if (state_r == ST_DRAIN) begin
      out_count_r <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_qualified_count = out_count_r;

`ifndef SYNTHESIS
  a_out_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("RAM written while idle");

  a_read_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> rd_vld_r)
    else $error("read data not marked valid after a read");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (rd_addr_q_r <= last_r))
    else $error("read beyond the end of the range");

  a_write_is_add: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != ST_CLEAR) |-> (op_r == OP_ADD && rd_vld_r))
    else $error("coverage written by a query");
`endif

endmodule

[src/rctc_ram.sv]
module rctc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
